### rtl/mandelbrot_smooth_escape_time_core_assert.svh
// Assertion macros for the Mandelbrot escape-time core
`ifndef MANDELBROT_SMOOTH_ESCAPE_TIME_CORE_ASSERT_SVH
`define MANDELBROT_SMOOTH_ESCAPE_TIME_CORE_ASSERT_SVH
`ifndef SYNTH
`define MSET_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define MSET_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MSET_ASSERT_IMP(lbl, ante, cons, msg)
`define MSET_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/mset_pkg.sv
// Shared types, constants and the log2 table of the Mandelbrot escape-time core
`default_nettype none
package mset_pkg;

  localparam int FRAC_BITS      = 36;
  localparam int ITER_BITS      = 32;
  localparam int MAX_SIDE       = 4096;
  localparam int LOG_TABLE_SIZE = 256;
  localparam int LOG_BITS       = $clog2(LOG_TABLE_SIZE);
  localparam int TAB_IDX_W      = LOG_BITS + 1;
  localparam int TAB_W          = 17;

  localparam int COORD_W    = 48;
  localparam int SPAN_W     = 47;
  localparam int PIX_W      = 12;
  localparam int SIZE_W     = 13;
  localparam int ERS_W      = 16;
  localparam int Z_W        = 64;
  localparam int HALF_W     = Z_W / 2;
  localparam int SQ_W       = 62;
  localparam int MAG_W      = SQ_W + 1;
  localparam int PROD_W     = 2 * Z_W;
  localparam int DIVD_W     = PIX_W + SPAN_W;
  localparam int MAP_W      = DIVD_W + 2;
  localparam int DIV_CNT_W  = $clog2(DIVD_W + 1);
  localparam int MSB_W      = $clog2(Z_W);
  localparam int LG_W       = 24;
  localparam int Q_FRAC     = 16;
  localparam int SMOOTH_W   = 48;
  localparam int SUM_W      = 50;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 48;
  localparam int MUL_STEPS  = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X     = 4'd0,
    REG_CENTER_Y     = 4'd1,
    REG_VIEW_WIDTH   = 4'd2,
    REG_VIEW_HEIGHT  = 4'd3,
    REG_ESCAPE_RSQ   = 4'd4,
    REG_MAX_ITER     = 4'd5,
    REG_IMAGE_WIDTH  = 4'd6,
    REG_IMAGE_HEIGHT = 4'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    MUL_MAP_X,
    MUL_MAP_Y,
    MUL_XX,
    MUL_YY,
    MUL_XY
  } mul_op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MAPX_MUL, S_MAPX_MULW, S_MAPX_DIV, S_MAPX_DIVW,
    S_MAPY_MUL, S_MAPY_MULW, S_MAPY_DIV, S_MAPY_DIVW,
    S_XX, S_XXW, S_YY, S_YYW, S_CHECK, S_XY, S_XYW,
    S_LOG1, S_LOG1W, S_LOG2, S_LOG2W,
    S_FINISH, S_OUT
  } state_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic signed [SMOOTH_W-1:0] smooth_count;
    logic [ITER_BITS-1:0]       iterations;
    logic                       escaped;
  } result_t;

  typedef struct packed {
    logic    load_pix;
    logic    mul_start;
    mul_op_e mul_op;
    logic    div_start;
    logic    axis_y;
    logic    load_c0;
    logic    init_z;
    logic    load_xx;
    logic    load_yy;
    logic    step_z;
    logic    log_start;
    logic    log_sel;
    logic    load_h;
    logic    finish;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic log_done;
    logic stop;
    logic escaped;
  } status_t;

  typedef logic [TAB_W-1:0] log_tab_t [LOG_TABLE_SIZE+1];

  // log2(1+k/N) in Q16 by repeated squaring, truncated
  function automatic log_tab_t build_log_tab();
    log_tab_t        t;
    logic [63:0]     x;
    logic [TAB_W-1:0] acc;
    for (int k = 0; k < LOG_TABLE_SIZE; k++) begin
      x = ((64'(LOG_TABLE_SIZE) + 64'(k)) << 30) / LOG_TABLE_SIZE;
      acc = '0;
      for (int b = 15; b >= 0; b--) begin
        x = (x * x) >> 30;
        if (x >= (64'd2 << 30)) begin
          x = x >> 1;
          acc = acc | (TAB_W'(1) << b);
        end
      end
      t[k] = acc;
    end
    t[LOG_TABLE_SIZE] = TAB_W'(65536);
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();

endpackage
`default_nettype wire

### rtl/mset_mul.sv
// Multi-cycle 64x64 multiplier built on one 32x32 partial-product unit
`default_nettype none
module mset_mul (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [mset_pkg::Z_W-1:0]    a_i,
  input  wire logic [mset_pkg::Z_W-1:0]    b_i,
  output logic                             done_o,
  output logic [mset_pkg::PROD_W-1:0]      prod_o
);

  localparam int HW = mset_pkg::HALF_W;

  logic [mset_pkg::Z_W-1:0]    a_q, b_q;
  logic [2:0]                  phase_q;
  logic                        busy_q, done_q;
  logic [mset_pkg::Z_W-1:0]    pp_q, pp_d;
  logic [mset_pkg::PROD_W-1:0] acc_q, addend;
  logic [HW-1:0]               op_a, op_b;

  always_comb begin
    case (phase_q)
      3'd0: begin
        op_a = a_q[HW-1:0];
        op_b = b_q[HW-1:0];
      end
      3'd1: begin
        op_a = a_q[HW-1:0];
        op_b = b_q[mset_pkg::Z_W-1:HW];
      end
      3'd2: begin
        op_a = a_q[mset_pkg::Z_W-1:HW];
        op_b = b_q[HW-1:0];
      end
      default: begin
        op_a = a_q[mset_pkg::Z_W-1:HW];
        op_b = b_q[mset_pkg::Z_W-1:HW];
      end
    endcase
    pp_d = op_a * op_b;
    // align the product formed in the previous cycle
    case (phase_q) inside
      3'd1:       addend = {{mset_pkg::Z_W{1'b0}}, pp_q};
      3'd2, 3'd3: addend = {{HW{1'b0}}, pp_q, {HW{1'b0}}};
      3'd4:       addend = {pp_q, {mset_pkg::Z_W{1'b0}}};
      default:    addend = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= '0;
    end else if (start_i) begin
      busy_q  <= 1'b1;
      done_q  <= 1'b0;
      phase_q <= '0;
    end else if (busy_q) begin
      phase_q <= phase_q + 3'd1;
      if (phase_q == 3'(mset_pkg::MUL_STEPS)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      pp_q  <= pp_d;
      acc_q <= acc_q + addend;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule
`default_nettype wire

### rtl/mset_div.sv
// Restoring divider, one quotient bit per cycle, for the pixel mapping
`default_nettype none
module mset_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [mset_pkg::DIVD_W-1:0]   dividend_i,
  input  wire logic [mset_pkg::SIZE_W-1:0]   divisor_i,
  output logic                               done_o,
  output logic [mset_pkg::DIVD_W-1:0]        quot_o
);

  localparam int SW = mset_pkg::SIZE_W;

  logic [SW-1:0]                    rem_q, dvs_q;
  logic [mset_pkg::DIVD_W-1:0]      quot_q;
  logic [mset_pkg::DIV_CNT_W-1:0]   cnt_q;
  logic                             busy_q, done_q;
  logic [SW:0]                      trial, diff;
  logic                             ge;

  always_comb begin
    trial = {rem_q, quot_q[mset_pkg::DIVD_W-1]};
    ge    = trial >= {1'b0, dvs_q};
    diff  = trial - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == mset_pkg::DIV_CNT_W'(mset_pkg::DIVD_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      dvs_q  <= divisor_i;
      quot_q <= dividend_i;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[SW-1:0] : trial[SW-1:0];
      quot_q <= {quot_q[mset_pkg::DIVD_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
`default_nettype wire

### rtl/mset_log.sv
// Table-based log2 unit: leading-one search, table lookup, interpolation
`default_nettype none
module mset_log (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [mset_pkg::Z_W-1:0]      val_i,
  output logic                               done_o,
  output logic [mset_pkg::MSB_W-1:0]         msb_o,
  output logic [mset_pkg::TAB_W-1:0]         frac_o
);

  localparam int ZW = mset_pkg::Z_W;
  localparam int HW = mset_pkg::HALF_W;
  localparam int LB = mset_pkg::LOG_BITS;
  localparam int TW = mset_pkg::TAB_W;
  localparam int IW = mset_pkg::TAB_IDX_W;

  logic [ZW-1:0]              m_q;
  logic [mset_pkg::MSB_W-1:0] k_q;
  logic [3:0]                 phase_q;
  logic                       busy_q, done_q;
  logic [TW-1:0]              t0_q, d_q, frac_q;
  logic [HW-1:0]              rem_q;
  logic [TW+HW-1:0]           dprod_q;

  logic [mset_pkg::MSB_W-1:0] amt;
  logic                       top_zero;
  logic [HW-1:0]              r32, rem_d;
  logic [LB-1:0]              idx;
  logic [TW-1:0]              t0, t1;

  always_comb begin
    amt      = mset_pkg::MSB_W'(HW >> phase_q);
    top_zero = (m_q & ~({ZW{1'b1}} >> amt)) == '0;
    r32      = m_q[ZW-2 -: HW];
    idx      = r32[HW-1 -: LB];
    rem_d    = {r32[HW-LB-1:0], {LB{1'b0}}};
    t0       = mset_pkg::LOG_TAB[IW'(idx)];
    t1       = mset_pkg::LOG_TAB[IW'(idx) + IW'(1)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= '0;
    end else if (start_i) begin
      busy_q  <= 1'b1;
      done_q  <= 1'b0;
      phase_q <= '0;
    end else if (busy_q) begin
      phase_q <= phase_q + 4'd1;
      if (phase_q == 4'(mset_pkg::MSB_W + 2)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      m_q <= val_i;
      k_q <= mset_pkg::MSB_W'(ZW - 1);
    end else if (busy_q) begin
      if (phase_q < 4'(mset_pkg::MSB_W)) begin
        // halve the search window each step
        if (top_zero) begin
          m_q <= m_q << amt;
          k_q <= k_q - amt;
        end
      end else if (phase_q == 4'(mset_pkg::MSB_W)) begin
        t0_q  <= t0;
        d_q   <= t1 - t0;
        rem_q <= rem_d;
      end else if (phase_q == 4'(mset_pkg::MSB_W + 1)) begin
        dprod_q <= d_q * rem_q;
      end else begin
        frac_q <= t0_q + dprod_q[TW+HW-1:HW];
      end
    end
  end

  assign done_o = done_q;
  assign msb_o  = k_q;
  assign frac_o = frac_q;

endmodule
`default_nettype wire

### rtl/mset_datapath.sv
// Datapath: configuration registers, mapping, z iteration and smooth count
`default_nettype none
module mset_datapath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  input  wire logic [mset_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [mset_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire mset_pkg::pixel_t                  pixel_i,
  input  wire mset_pkg::cmd_t                    cmd_i,
  output mset_pkg::status_t                      status_o,
  output mset_pkg::result_t                      result_o
);

  localparam int ZW = mset_pkg::Z_W;
  localparam int CW = mset_pkg::COORD_W;
  localparam int MW = mset_pkg::MAP_W;
  localparam int LW = mset_pkg::LG_W;
  localparam int UW = mset_pkg::SUM_W;
  localparam int QF = mset_pkg::Q_FRAC;

  function automatic logic [mset_pkg::SIZE_W-1:0] clamp_size(
    input logic [mset_pkg::SIZE_W-1:0] s
  );
    if (s == '0) return mset_pkg::SIZE_W'(1);
    if (s > mset_pkg::SIZE_W'(mset_pkg::MAX_SIDE)) return mset_pkg::SIZE_W'(mset_pkg::MAX_SIDE);
    return s;
  endfunction

  // truncating shift of a product magnitude, saturated
  function automatic logic [mset_pkg::SQ_W-1:0] sat_shift(
    input logic [mset_pkg::PROD_W-1:0] p,
    input int sh
  );
    logic [mset_pkg::PROD_W-1:0] s;
    s = p >> sh;
    if (|s[mset_pkg::PROD_W-1:mset_pkg::SQ_W]) return '1;
    return s[mset_pkg::SQ_W-1:0];
  endfunction

  function automatic logic signed [LW-1:0] log_val(
    input logic [mset_pkg::MSB_W-1:0] k,
    input logic [mset_pkg::TAB_W-1:0] f,
    input int fb
  );
    logic signed [LW-1:0] e;
    e = $signed(LW'(k)) - $signed(LW'(fb));
    return (e <<< QF) + $signed(LW'(f));
  endfunction

  // configuration
  logic [CW-1:0]                   cx_q, cy_q;
  logic [mset_pkg::SPAN_W-1:0]     vw_q, vh_q;
  logic [mset_pkg::ERS_W-1:0]      ers_q;
  logic [mset_pkg::ITER_BITS-1:0]  max_it_q;
  logic [mset_pkg::SIZE_W-1:0]     iw_q, ih_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= '0;
      cy_q     <= '0;
      vw_q     <= mset_pkg::SPAN_W'(64'd274877906944);
      vh_q     <= mset_pkg::SPAN_W'(64'd274877906944);
      ers_q    <= mset_pkg::ERS_W'(4);
      max_it_q <= mset_pkg::ITER_BITS'(256);
      iw_q     <= mset_pkg::SIZE_W'(1024);
      ih_q     <= mset_pkg::SIZE_W'(1024);
    end else if (cfg_valid_i) begin
      unique case (mset_pkg::cfg_reg_e'(cfg_index_i))
        mset_pkg::REG_CENTER_X:     cx_q     <= cfg_data_i[CW-1:0];
        mset_pkg::REG_CENTER_Y:     cy_q     <= cfg_data_i[CW-1:0];
        mset_pkg::REG_VIEW_WIDTH:   vw_q     <= cfg_data_i[mset_pkg::SPAN_W-1:0];
        mset_pkg::REG_VIEW_HEIGHT:  vh_q     <= cfg_data_i[mset_pkg::SPAN_W-1:0];
        mset_pkg::REG_ESCAPE_RSQ:   ers_q    <= cfg_data_i[mset_pkg::ERS_W-1:0];
        mset_pkg::REG_MAX_ITER:     max_it_q <= cfg_data_i[mset_pkg::ITER_BITS-1:0];
        mset_pkg::REG_IMAGE_WIDTH:  iw_q     <= cfg_data_i[mset_pkg::SIZE_W-1:0];
        mset_pkg::REG_IMAGE_HEIGHT: ih_q     <= cfg_data_i[mset_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // working registers
  logic [mset_pkg::PIX_W-1:0]      px_q, py_q;
  logic [CW-1:0]                   x0_q, y0_q;
  logic [ZW-1:0]                   x_q, y_q;
  logic [mset_pkg::SQ_W-1:0]       xx_q, yy_q;
  logic [mset_pkg::ITER_BITS-1:0]  iter_q;
  logic [LW-1:0]                   h_q;
  mset_pkg::result_t               result_q;

  // shared units
  logic [ZW-1:0]                   mul_a, mul_b, abs_x, abs_y;
  logic                            mul_done, div_done, log_done;
  logic [mset_pkg::PROD_W-1:0]     prod;
  logic [mset_pkg::DIVD_W-1:0]     quot;
  logic [mset_pkg::SIZE_W-1:0]     divisor;
  logic [ZW-1:0]                   log_in;
  logic [mset_pkg::MSB_W-1:0]      log_k;
  logic [mset_pkg::TAB_W-1:0]      log_f;

  logic [mset_pkg::MAG_W-1:0]      mag;
  logic                            esc;
  logic signed [MW-1:0]            map_sum;
  logic [CW-1:0]                   map_sat;
  logic [mset_pkg::SQ_W-1:0]       xym;
  logic [ZW-1:0]                   xy_s, x_next, y_next;
  logic signed [LW-1:0]            l1, l1_adj, half, nu;
  logic signed [UW-1:0]            total;
  logic [mset_pkg::SMOOTH_W-1:0]   smooth_sat;

  always_comb begin
    abs_x = x_q[ZW-1] ? (~x_q + ZW'(1)) : x_q;
    abs_y = y_q[ZW-1] ? (~y_q + ZW'(1)) : y_q;
    unique case (cmd_i.mul_op)
      mset_pkg::MUL_MAP_X: begin
        mul_a = ZW'(px_q);
        mul_b = ZW'(vw_q);
      end
      mset_pkg::MUL_MAP_Y: begin
        mul_a = ZW'(py_q);
        mul_b = ZW'(vh_q);
      end
      mset_pkg::MUL_XX: begin
        mul_a = abs_x;
        mul_b = abs_x;
      end
      mset_pkg::MUL_YY: begin
        mul_a = abs_y;
        mul_b = abs_y;
      end
      mset_pkg::MUL_XY: begin
        mul_a = abs_x;
        mul_b = abs_y;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    divisor = cmd_i.axis_y ? clamp_size(ih_q) : clamp_size(iw_q);

    // c = centre - span/2 + pixel*span/size, saturated
    if (cmd_i.axis_y) begin
      map_sum = $signed({{(MW-CW){cy_q[CW-1]}}, cy_q}) - $signed(MW'(vh_q >> 1))
              + $signed(MW'(quot));
    end else begin
      map_sum = $signed({{(MW-CW){cx_q[CW-1]}}, cx_q}) - $signed(MW'(vw_q >> 1))
              + $signed(MW'(quot));
    end
    if (map_sum[MW-1:CW-1] == '0 || map_sum[MW-1:CW-1] == '1) begin
      map_sat = map_sum[CW-1:0];
    end else begin
      map_sat = map_sum[MW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end

    mag    = {1'b0, xx_q} + {1'b0, yy_q};
    esc    = iter_q < max_it_q;
    xym    = sat_shift(prod, mset_pkg::FRAC_BITS - 1);
    xy_s   = (x_q[ZW-1] ^ y_q[ZW-1]) ? (~ZW'(xym) + ZW'(1)) : ZW'(xym);
    x_next = ZW'(xx_q) - ZW'(yy_q) + {{(ZW-CW){x0_q[CW-1]}}, x0_q};
    y_next = xy_s + {{(ZW-CW){y0_q[CW-1]}}, y0_q};

    log_in = cmd_i.log_sel ? ZW'(h_q) : ZW'(mag);

    // log2|z| = log2(|z|^2)/2, rounded toward zero
    l1     = log_val(log_k, log_f, mset_pkg::FRAC_BITS);
    l1_adj = l1 + $signed({{(LW-1){1'b0}}, l1[LW-1]});
    half   = l1_adj >>> 1;
    nu     = log_val(log_k, log_f, QF);

    total = $signed({2'b0, iter_q, {QF{1'b0}}});
    if (esc) begin
      total = total + $signed(UW'(1) << QF) - UW'(nu);
    end
    if (total[UW-1:mset_pkg::SMOOTH_W-1] == '0 || total[UW-1:mset_pkg::SMOOTH_W-1] == '1) begin
      smooth_sat = total[mset_pkg::SMOOTH_W-1:0];
    end else begin
      smooth_sat = total[UW-1] ? {1'b1, {(mset_pkg::SMOOTH_W-1){1'b0}}}
                               : {1'b0, {(mset_pkg::SMOOTH_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pix) begin
      px_q <= pixel_i.pixel_x;
      py_q <= pixel_i.pixel_y;
    end
    if (cmd_i.load_c0) begin
      if (cmd_i.axis_y) y0_q <= map_sat;
      else              x0_q <= map_sat;
    end
    if (cmd_i.init_z) begin
      x_q    <= '0;
      y_q    <= '0;
      iter_q <= '0;
    end
    if (cmd_i.load_xx) xx_q <= sat_shift(prod, mset_pkg::FRAC_BITS);
    if (cmd_i.load_yy) yy_q <= sat_shift(prod, mset_pkg::FRAC_BITS);
    if (cmd_i.step_z) begin
      x_q    <= x_next;
      y_q    <= y_next;
      iter_q <= iter_q + 1'b1;
    end
    if (cmd_i.load_h) begin
      // a zero or non-positive log2|z| is taken as the smallest step
      if (mag == '0 || half < $signed(LW'(1))) h_q <= LW'(1);
      else                                      h_q <= half;
    end
    if (cmd_i.finish) begin
      result_q.smooth_count <= smooth_sat;
      result_q.iterations   <= iter_q;
      result_q.escaped      <= esc;
    end
  end

  mset_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  mset_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod[mset_pkg::DIVD_W-1:0]),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  mset_log u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.log_start),
    .val_i   (log_in),
    .done_o  (log_done),
    .msb_o   (log_k),
    .frac_o  (log_f)
  );

  always_comb begin
    status_o.mul_done = mul_done;
    status_o.div_done = div_done;
    status_o.log_done = log_done;
    status_o.stop     = (mag[mset_pkg::MAG_W-1:mset_pkg::FRAC_BITS]
                         >= (mset_pkg::MAG_W - mset_pkg::FRAC_BITS)'(ers_q)) || !esc;
    status_o.escaped  = esc;
  end

  assign result_o = result_q;

endmodule
`default_nettype wire

### rtl/mset_ctrl.sv
// Controller: sequences mapping, iteration, log steps and the result strobe
`default_nettype none
module mset_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire mset_pkg::status_t  status_i,
  output mset_pkg::cmd_t          cmd_o,
  output logic                    busy_o,
  output logic                    done_o
);

  mset_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= mset_pkg::S_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      mset_pkg::S_IDLE: begin
        if (start_i) begin
          cmd_o.load_pix = 1'b1;
          state_d = mset_pkg::S_MAPX_MUL;
        end
      end
      mset_pkg::S_MAPX_MUL: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_op    = mset_pkg::MUL_MAP_X;
        state_d = mset_pkg::S_MAPX_MULW;
      end
      mset_pkg::S_MAPX_MULW: begin
        if (status_i.mul_done) state_d = mset_pkg::S_MAPX_DIV;
      end
      mset_pkg::S_MAPX_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d = mset_pkg::S_MAPX_DIVW;
      end
      mset_pkg::S_MAPX_DIVW: begin
        if (status_i.div_done) begin
          cmd_o.load_c0 = 1'b1;
          state_d = mset_pkg::S_MAPY_MUL;
        end
      end
      mset_pkg::S_MAPY_MUL: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_op    = mset_pkg::MUL_MAP_Y;
        state_d = mset_pkg::S_MAPY_MULW;
      end
      mset_pkg::S_MAPY_MULW: begin
        if (status_i.mul_done) state_d = mset_pkg::S_MAPY_DIV;
      end
      mset_pkg::S_MAPY_DIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.axis_y    = 1'b1;
        state_d = mset_pkg::S_MAPY_DIVW;
      end
      mset_pkg::S_MAPY_DIVW: begin
        cmd_o.axis_y = 1'b1;
        if (status_i.div_done) begin
          cmd_o.load_c0 = 1'b1;
          cmd_o.init_z  = 1'b1;
          state_d = mset_pkg::S_XX;
        end
      end
      mset_pkg::S_XX: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_op    = mset_pkg::MUL_XX;
        state_d = mset_pkg::S_XXW;
      end
      mset_pkg::S_XXW: begin
        if (status_i.mul_done) begin
          cmd_o.load_xx = 1'b1;
          state_d = mset_pkg::S_YY;
        end
      end
      mset_pkg::S_YY: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_op    = mset_pkg::MUL_YY;
        state_d = mset_pkg::S_YYW;
      end
      mset_pkg::S_YYW: begin
        if (status_i.mul_done) begin
          cmd_o.load_yy = 1'b1;
          state_d = mset_pkg::S_CHECK;
        end
      end
      mset_pkg::S_CHECK: begin
        if (!status_i.stop)         state_d = mset_pkg::S_XY;
        else if (status_i.escaped)  state_d = mset_pkg::S_LOG1;
        else                        state_d = mset_pkg::S_FINISH;
      end
      mset_pkg::S_XY: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_op    = mset_pkg::MUL_XY;
        state_d = mset_pkg::S_XYW;
      end
      mset_pkg::S_XYW: begin
        if (status_i.mul_done) begin
          cmd_o.step_z = 1'b1;
          state_d = mset_pkg::S_XX;
        end
      end
      mset_pkg::S_LOG1: begin
        cmd_o.log_start = 1'b1;
        state_d = mset_pkg::S_LOG1W;
      end
      mset_pkg::S_LOG1W: begin
        if (status_i.log_done) begin
          cmd_o.load_h = 1'b1;
          state_d = mset_pkg::S_LOG2;
        end
      end
      mset_pkg::S_LOG2: begin
        cmd_o.log_start = 1'b1;
        cmd_o.log_sel   = 1'b1;
        state_d = mset_pkg::S_LOG2W;
      end
      mset_pkg::S_LOG2W: begin
        if (status_i.log_done) state_d = mset_pkg::S_FINISH;
      end
      mset_pkg::S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d = mset_pkg::S_OUT;
      end
      mset_pkg::S_OUT: begin
        state_d = mset_pkg::S_IDLE;
      end
      default: state_d = mset_pkg::S_IDLE;
    endcase
  end

  assign busy_o = state_q != mset_pkg::S_IDLE;
  assign done_o = state_q == mset_pkg::S_OUT;

endmodule
`default_nettype wire

### rtl/mandelbrot_smooth_escape_time_core.sv
// Top level of the Mandelbrot escape-time core with smooth iteration count
//
// A pixel word is taken on pixel_i at a clock edge with start_i high and
// busy_o low. The block maps it to a point c, iterates z = z*z + c and
// returns one result word on result_o, marked by done_o for one cycle.
// The receiver cannot stall: the word must be taken in that cycle.
// Configuration goes through cfg_valid_i/cfg_index_i/cfg_data_i; cfg_ready_o
// is always high and writes belong to idle periods.
// Every wide product goes through one shared 32x32 multiplier as four
// partial products; each mapping division runs one quotient bit per cycle.
// Two log2 passes follow the iteration when the point escapes.
// One item is in work at a time; busy_o stays high from acceptance through
// the done_o cycle.
// Reset restores the default view (centre 0, span 4.0, 1024x1024 image,
// escape bound 4, limit 256) and returns the controller to idle.
`default_nettype none
module mandelbrot_smooth_escape_time_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire mset_pkg::pixel_t                  pixel_i,
  output logic                                   done_o,
  output mset_pkg::result_t                      result_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [mset_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [mset_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  `include "mandelbrot_smooth_escape_time_core_assert.svh"

  mset_pkg::cmd_t    cmd;
  mset_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  mset_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  mset_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pixel_i     (pixel_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .result_o    (result_o)
  );

  `MSET_ASSERT_NXT(a_accept_busy, start_i && !busy_o, busy_o, "accepted word did not raise busy")
  `MSET_ASSERT_NXT(a_done_idle, done_o, !busy_o && !done_o, "result strobe not followed by idle")
  `MSET_ASSERT_IMP(a_one_unit, cmd.mul_start, !cmd.div_start && !cmd.log_start, "two units started")
  `MSET_ASSERT_IMP(a_done_busy, done_o, busy_o && !cmd.load_pix, "result strobe while idle")

endmodule
`default_nettype wire
